// ===== rtl/shk_pkg.sv =====
// Shared types, widths and codes of the sorted hash key table.
package shk_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP     = 3'd0,
		CMD_INSERT     = 3'd1,
		CMD_REMOVE_KEY = 3'd2,
		CMD_REMOVE_AT  = 3'd3,
		CMD_READ_AT    = 3'd4,
		CMD_CLEAR      = 3'd5
	} cmd_e;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_MISS  = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		STATE_IDLE,
		STATE_PROBE,
		STATE_APPLY
	} state_e;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] key_hash;
		logic [DATA_W-1:0] entry_handle;
		logic [DATA_W-1:0] entry_flags;
		logic [POS_W-1:0]  position;
	} req_word_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  found_position;
		logic [DATA_W-1:0] found_key;
		logic [DATA_W-1:0] found_handle;
		logic [DATA_W-1:0] found_flags;
		logic [CNT_W-1:0]  entry_count;
	} res_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] handle;
		logic [DATA_W-1:0] flags;
	} entry_t;

	// Update controls broadcast to every cell during the apply cycle.
	typedef struct packed {
		logic insert_go;
		logic remove_key_go;
		logic remove_at_go;
		logic use_pos;
	} cell_ctrl_t;

endpackage

// ===== rtl/shk_cell.sv =====
// One table slot: holds an entry, compares it against the probe and shifts with its neighbors.
module shk_cell import shk_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX = 0,
	localparam int unsigned IW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              probe_en,
	input  logic [DATA_W-1:0] probe_key,
	input  logic [CW-1:0]     count,
	input  logic [POS_W-1:0]  position,
	input  cell_ctrl_t        ctrl,
	input  entry_t            new_entry,
	input  entry_t            left_entry,
	input  entry_t            right_entry,
	input  logic              left_lt,
	output entry_t            entry,
	output logic              lt,
	output logic              hit,
	output logic              sel,
	output entry_t            rep_entry,
	output logic [IW-1:0]     rep_idx,
	output logic [IW-1:0]     ins_idx
);

	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CMPW-1:0] MY_POS = CMPW'(IDX);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	entry_t entry_q;
	logic   lt_q;
	logic   eq_q;
	logic   at_q;
	logic   ge_q;
	logic   valid;
	logic   boundary;

	assign valid = MY_POS < CMPW'(count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
			at_q <= 1'b0;
			ge_q <= 1'b0;
		end else if (probe_en) begin
			lt_q <= valid && (entry_q.key < probe_key);
			eq_q <= valid && (entry_q.key == probe_key);
			at_q <= valid && (MY_POS == CMPW'(position));
			ge_q <= MY_POS >= CMPW'(position);
		end
	end

	// The insertion point is the first slot whose key is not below the probe.
	assign boundary = left_lt && !lt_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert_go) begin
			if (boundary) begin
				entry_q <= new_entry;
			end else if (!left_lt) begin
				entry_q <= left_entry;
			end
		end else if (ctrl.remove_key_go && !lt_q) begin
			entry_q <= right_entry;
		end else if (ctrl.remove_at_go && ge_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry     = entry_q;
	assign lt        = lt_q;
	assign hit       = eq_q;
	assign sel       = ctrl.use_pos ? at_q : eq_q;
	assign rep_entry = sel ? entry_q : '0;
	assign rep_idx   = sel ? MY_IDX : '0;
	assign ins_idx   = boundary ? MY_IDX : '0;

endmodule

// ===== rtl/sorted_hash_key_table.sv =====
// Top level of the sorted hash key table: control, entry count and the row of cells.
//
// The table holds up to DEPTH entries (key hash, handle, flags) sorted ascending by key,
// one entry per cell in a row of identical cells. A command word is taken on request at
// a clock edge where start is high and busy is low. Each command gives exactly one result
// word on result, marked by done for a single cycle; the receiver cannot stall it.
// A command passes through a probe cycle, in which every cell compares its key and position
// against the request in parallel, and an apply cycle, in which the result is formed
// and the cells shift left or right by one place to open or close a gap. done is high in
// the cycle after the apply cycle. busy is high only in the probe cycle, so a new command
// may be started during the apply cycle of the last one.
// Reset empties the table by clearing the entry count; the cell contents are not
// cleared, since only slots below the count are ever compared or reported.
// Result positions and the count are reported in the low bits of their fields.
module sorted_hash_key_table import shk_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  req_word_t request,
	output logic      done,
	output res_word_t result
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

	state_e     state_q;
	state_e     state_next;
	req_word_t  req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	res_word_t  result_q;
	res_word_t  res_next;
	logic       done_q;
	cell_ctrl_t ctrl;

	entry_t        new_entry;
	entry_t        cell_entry [DEPTH];
	entry_t        rep_entry [DEPTH];
	logic [IW-1:0] rep_idx [DEPTH];
	logic [IW-1:0] ins_idx [DEPTH];
	logic [DEPTH-1:0] lt_vec;
	logic [DEPTH-1:0] eq_vec;
	logic [DEPTH-1:0] sel_vec;

	entry_t        sel_entry;
	logic [IW-1:0] sel_idx;
	logic [IW-1:0] ins_pos;
	logic          key_hit;
	logic          in_range;
	logic          table_full;
	logic          accept;
	logic [IW+POS_W-1:0] sel_pos_wide;
	logic [IW+POS_W-1:0] ins_pos_wide;
	logic [CW+CNT_W-1:0] count_wide;

	assign accept = start && !busy;
	assign busy   = (state_q == STATE_PROBE);

	// The request is held for the probe and apply cycles.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			count_q <= count_next;
			done_q  <= (state_q == STATE_APPLY);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == STATE_APPLY) begin
			result_q <= res_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			STATE_IDLE: begin
				if (start) begin
					state_next = STATE_PROBE;
				end
			end
			STATE_PROBE: begin
				state_next = STATE_APPLY;
			end
			STATE_APPLY: begin
				// A command started during the apply cycle probes the updated row.
				state_next = start ? STATE_PROBE : STATE_IDLE;
			end
			default: begin
				state_next = STATE_IDLE;
			end
		endcase
	end

	assign new_entry.key    = req_q.key_hash;
	assign new_entry.handle = req_q.entry_handle;
	assign new_entry.flags  = req_q.entry_flags;

	// The row of cells. Each cell sees the broadcast probe and the cells on either side of it.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   left_lt;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_entry = new_entry;
		end else begin : g_inner_left
			assign left_lt    = lt_vec[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = cell_entry[i];
		end else begin : g_inner_right
			assign right_entry = cell_entry[i+1];
		end

		shk_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.probe_en   (state_q == STATE_PROBE),
			.probe_key  (req_q.key_hash),
			.count      (count_q),
			.position   (req_q.position),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.left_lt    (left_lt),
			.entry      (cell_entry[i]),
			.lt         (lt_vec[i]),
			.hit        (eq_vec[i]),
			.sel        (sel_vec[i]),
			.rep_entry  (rep_entry[i]),
			.rep_idx    (rep_idx[i]),
			.ins_idx    (ins_idx[i])
		);
	end

	// At most one cell reports and at most one marks the insertion point, so the
	// masked outputs of all cells are simply ORed together.
	always_comb begin
		sel_entry = '0;
		sel_idx   = '0;
		ins_pos   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_entry = sel_entry | rep_entry[i];
			sel_idx   = sel_idx | rep_idx[i];
			ins_pos   = ins_pos | ins_idx[i];
		end
	end

	assign key_hit    = |eq_vec;
	assign in_range   = CMPW'(req_q.position) < CMPW'(count_q);
	assign table_full = (count_q == CW'(DEPTH));

	assign sel_pos_wide = (IW + POS_W)'(sel_idx);
	assign ins_pos_wide = (IW + POS_W)'(ins_pos);

	// Result and updates of the apply cycle.
	always_comb begin
		res_next            = '0;
		res_next.status     = STAT_OK;
		count_next          = count_q;
		ctrl                = '0;
		if (state_q == STATE_APPLY) begin
			ctrl.use_pos = (req_q.command == CMD_REMOVE_AT) || (req_q.command == CMD_READ_AT);
			case (cmd_e'(req_q.command))
				CMD_LOOKUP: begin
					if (!key_hit) begin
						res_next.status = STAT_MISS;
					end
				end
				CMD_INSERT: begin
					if (key_hit) begin
						res_next.status = STAT_MISS;
					end else if (table_full) begin
						res_next.status = STAT_FULL;
					end else begin
						ctrl.insert_go = 1'b1;
						count_next     = count_q + CW'(1);
					end
				end
				CMD_REMOVE_KEY: begin
					if (key_hit) begin
						ctrl.remove_key_go = 1'b1;
						count_next         = count_q - CW'(1);
					end else begin
						res_next.status = STAT_MISS;
					end
				end
				CMD_REMOVE_AT: begin
					if (in_range) begin
						ctrl.remove_at_go = 1'b1;
						count_next        = count_q - CW'(1);
					end else begin
						res_next.status = STAT_RANGE;
					end
				end
				CMD_READ_AT: begin
					if (!in_range) begin
						res_next.status = STAT_RANGE;
					end
				end
				CMD_CLEAR: begin
					count_next = '0;
				end
				default: begin
				end
			endcase

			if (ctrl.insert_go) begin
				// A fresh insert reports the new entry at its sorted position.
				res_next.found_position = ins_pos_wide[POS_W-1:0];
				res_next.found_key      = new_entry.key;
				res_next.found_handle   = new_entry.handle;
				res_next.found_flags    = new_entry.flags;
			end else if ((req_q.command <= CMD_READ_AT) && (res_next.status != STAT_FULL)) begin
				// Clear, unused codes and an insert into a full table report no entry. A key
				// miss or an out-of-range position reads zero; a duplicate insert reports its match.
				res_next.found_position = sel_pos_wide[POS_W-1:0];
				res_next.found_key      = sel_entry.key;
				res_next.found_handle   = sel_entry.handle;
				res_next.found_flags    = sel_entry.flags;
			end
		end
		count_wide           = (CW + CNT_W)'(count_next);
		res_next.entry_count = count_wide[CNT_W-1:0];
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_vec))
		else $error("more than one cell matches the probe key");

	a_single_report: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec))
		else $error("more than one cell selected for the result");

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == STATE_APPLY))
		else $error("result strobe without an apply cycle");

	a_count_changes_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(state_q == STATE_APPLY))
		else $error("entry count changed outside an apply cycle");
`endif

endmodule
